[rtl/sphk_pkg.sv]
// Types and constants shared by the SPH cubic spline kernel pipeline.
package sphk_pkg;

  localparam int unsigned RegInvH     = 0;
  localparam int unsigned RegValScale = 1;
  localparam int unsigned RegGrdScale = 2;

  localparam logic [31:0] InvHReset     = 32'd167772160;
  localparam logic [31:0] ValScaleReset = 32'd31291160;
  localparam logic [31:0] GrdScaleReset = 32'd312911600;

  localparam logic signed [33:0] TwoThirdsQ30 = 34'sd715827883;
  localparam logic [31:0]        DivSixMagic  = 32'd2863311531;

  localparam int unsigned RootBits = 33;
  localparam int unsigned QuoBits  = 34;

  typedef struct packed {
    logic [2:0][32:0]  ad;
    logic [2:0]        dpos;
    logic [2:0][65:0]  sq;
    logic [65:0]       rem;
    logic [32:0]       root;
    logic [64:0]       prod;
    logic              in_supp;
    logic              lt1;
    logic [30:0]       x;
    logic [30:0]       x2;
    logic [30:0]       x3;
    logic signed [33:0] fa;
    logic signed [33:0] ga;
    logic [62:0]       t6;
    logic [30:0]       f;
    logic [30:0]       g;
    logic [31:0]       w;
    logic [31:0]       mag;
    logic [2:0][65:0]  dvrem;
    logic [2:0][33:0]  quo;
    logic [2:0][31:0]  grad;
    logic              coinc;
  } item_t;

endpackage

[rtl/sph_cubic_kernel_and_gradient.sv]
// Top level: pipelined 3D cubic spline SPH kernel value and gradient.
//
// One particle pair enters per cycle while the output is not stalled. The pipeline depth is
// set by the bit-per-stage square root (33 stages) and the bit-per-stage divisions of the
// gradient components (34 stages). Every stage has its own valid bit and holds its item
// only while the stage after it is full and stalled, so bubbles are squeezed out and input
// is taken while a finished result waits. Registers are to be written through the APB port
// only while the pipeline is empty; the block itself does not enforce this.
module sph_cubic_kernel_and_gradient (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kernel_value, grad_x, grad_y, grad_z
  output logic [127:0] m_axis_tdata,
  // coincident
  output logic         m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import sphk_pkg::*;

  localparam int StD   = 0;
  localparam int StSq  = 1;
  localparam int StN   = 2;
  localparam int StRt0 = 3;
  localparam int StP   = StRt0 + RootBits;
  localparam int StX   = StP + 1;
  localparam int StX2  = StX + 1;
  localparam int StX3  = StX2 + 1;
  localparam int StF   = StX3 + 1;
  localparam int StG   = StF + 1;
  localparam int StW   = StG + 1;
  localparam int StM   = StW + 1;
  localparam int StDv0 = StM + 1;
  localparam int StO   = StDv0 + QuoBits;
  localparam int Depth = StO + 1;

  logic [31:0] inv_h_q, val_scale_q, grd_scale_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_h_q     <= InvHReset;
      val_scale_q <= ValScaleReset;
      grd_scale_q <= GrdScaleReset;
    end else if (cfg_wr) begin
      if (paddr[3:2] == 2'(RegInvH))     inv_h_q     <= pwdata;
      if (paddr[3:2] == 2'(RegValScale)) val_scale_q <= pwdata;
      if (paddr[3:2] == 2'(RegGrdScale)) grd_scale_q <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == 2'(RegInvH))     prdata = inv_h_q;
    if (paddr[3:2] == 2'(RegValScale)) prdata = val_scale_q;
    if (paddr[3:2] == 2'(RegGrdScale)) prdata = grd_scale_q;
  end

  item_t             pipe_q [Depth];
  item_t             nx     [Depth];
  logic [Depth-1:0]  v_q;
  logic [Depth:0]    rdy;

  always_comb begin
    rdy[Depth] = m_axis_tready;
    for (int k = Depth - 1; k >= 0; k--) rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign s_axis_tready = rdy[0];

  always_comb begin
    logic signed [32:0] diff;
    nx[StD] = pipe_q[StD];
    for (int i = 0; i < 3; i++) begin
      diff = $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]})
           - $signed({s_axis_tdata[32*i+127], s_axis_tdata[32*i+96 +: 32]});
      nx[StD].ad[i]   = diff[32] ? 33'(-diff) : 33'(diff);
      nx[StD].dpos[i] = !diff[32] && (diff != '0);
    end
  end

  for (genvar k = 1; k < Depth; k++) begin : g_stage
    if (k == StSq) begin : g_sq
      always_comb begin
        nx[k] = pipe_q[k-1];
        for (int i = 0; i < 3; i++) nx[k].sq[i] = 66'(pipe_q[k-1].ad[i]) * 66'(pipe_q[k-1].ad[i]);
      end
    end else if (k == StN) begin : g_sum
      always_comb begin
        nx[k]      = pipe_q[k-1];
        nx[k].rem  = pipe_q[k-1].sq[0] + pipe_q[k-1].sq[1] + pipe_q[k-1].sq[2];
        nx[k].root = '0;
      end
    end else if (k >= StRt0 && k < StP) begin : g_root
      localparam int B = StP - 1 - k;
      always_comb begin
        logic [67:0] inc;
        nx[k] = pipe_q[k-1];
        inc   = (68'(pipe_q[k-1].root) << (B + 1)) + (68'd1 << (2 * B));
        if (inc <= 68'(pipe_q[k-1].rem)) begin
          nx[k].rem     = pipe_q[k-1].rem - inc[65:0];
          nx[k].root[B] = 1'b1;
        end
      end
    end else if (k == StP) begin : g_prod
      always_comb begin
        nx[k]      = pipe_q[k-1];
        nx[k].prod = 65'(pipe_q[k-1].root) * 65'(inv_h_q);
      end
    end else if (k == StX) begin : g_x
      always_comb begin
        logic [30:0] q;
        nx[k]         = pipe_q[k-1];
        q             = pipe_q[k-1].prod[48:18];
        nx[k].in_supp = (pipe_q[k-1].prod[64:49] == '0);
        nx[k].lt1     = !q[30];
        nx[k].x       = q[30] ? 31'(32'h8000_0000 - {1'b0, q}) : q;
      end
    end else if (k == StX2) begin : g_x2
      always_comb begin
        logic [61:0] p;
        nx[k]    = pipe_q[k-1];
        p        = 62'(pipe_q[k-1].x) * 62'(pipe_q[k-1].x);
        nx[k].x2 = p[60:30];
      end
    end else if (k == StX3) begin : g_x3
      always_comb begin
        logic [61:0] p;
        nx[k]    = pipe_q[k-1];
        p        = 62'(pipe_q[k-1].x2) * 62'(pipe_q[k-1].x);
        nx[k].x3 = p[60:30];
      end
    end else if (k == StF) begin : g_f
      always_comb begin
        logic [32:0] x2t3;
        nx[k]    = pipe_q[k-1];
        x2t3     = {1'b0, pipe_q[k-1].x2, 1'b0} + 33'(pipe_q[k-1].x2);
        nx[k].fa = TwoThirdsQ30 - $signed({3'b0, pipe_q[k-1].x2})
                 + $signed({4'b0, pipe_q[k-1].x3[30:1]});
        nx[k].ga = $signed({2'b0, pipe_q[k-1].x, 1'b0}) - $signed({2'b0, x2t3[32:1]});
        nx[k].t6 = 63'(pipe_q[k-1].x3) * 63'(DivSixMagic);
      end
    end else if (k == StG) begin : g_g
      always_comb begin
        nx[k] = pipe_q[k-1];
        if (!pipe_q[k-1].in_supp) begin
          nx[k].f = '0;
          nx[k].g = '0;
        end else if (pipe_q[k-1].lt1) begin
          nx[k].f = pipe_q[k-1].fa[33] ? '0 : pipe_q[k-1].fa[30:0];
          nx[k].g = pipe_q[k-1].ga[33] ? '0 : pipe_q[k-1].ga[30:0];
        end else begin
          nx[k].f = 31'(pipe_q[k-1].t6[62:34]);
          nx[k].g = {1'b0, pipe_q[k-1].x2[30:1]};
        end
      end
    end else if (k == StW) begin : g_w
      always_comb begin
        logic [62:0] pw, pg;
        nx[k]     = pipe_q[k-1];
        pw        = 63'(val_scale_q) * 63'(pipe_q[k-1].f);
        pg        = 63'(grd_scale_q) * 63'(pipe_q[k-1].g);
        nx[k].w   = pw[62] ? '1 : pw[61:30];
        nx[k].mag = pg[62] ? '1 : pg[61:30];
      end
    end else if (k == StM) begin : g_m
      always_comb begin
        nx[k] = pipe_q[k-1];
        for (int i = 0; i < 3; i++) begin
          nx[k].dvrem[i] = 66'(pipe_q[k-1].mag) * 66'(pipe_q[k-1].ad[i]);
          nx[k].quo[i]   = '0;
        end
      end
    end else if (k >= StDv0 && k < StO) begin : g_div
      localparam int B = StO - 1 - k;
      always_comb begin
        logic [67:0] sub;
        nx[k] = pipe_q[k-1];
        sub   = 68'(pipe_q[k-1].root) << B;
        for (int i = 0; i < 3; i++) begin
          if (68'(pipe_q[k-1].dvrem[i]) >= sub) begin
            nx[k].dvrem[i]  = pipe_q[k-1].dvrem[i] - sub[65:0];
            nx[k].quo[i][B] = 1'b1;
          end
        end
      end
    end else begin : g_out
      always_comb begin
        logic [33:0] m;
        nx[k]       = pipe_q[k-1];
        nx[k].coinc = (pipe_q[k-1].root == '0);
        for (int i = 0; i < 3; i++) begin
          m = pipe_q[k-1].quo[i];
          if (pipe_q[k-1].root == '0) begin
            nx[k].grad[i] = '0;
          end else if (pipe_q[k-1].dpos[i]) begin
            if (m > 34'h0_8000_0000) m = 34'h0_8000_0000;
            nx[k].grad[i] = 32'(-m);
          end else begin
            if (m > 34'h0_7FFF_FFFF) m = 34'h0_7FFF_FFFF;
            nx[k].grad[i] = m[31:0];
          end
        end
      end
    end
  end

  for (genvar k = 0; k < Depth; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (rdy[k]) pipe_q[k] <= nx[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < Depth; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign m_axis_tvalid = v_q[Depth-1];
  assign m_axis_tdata  = {pipe_q[Depth-1].grad[2], pipe_q[Depth-1].grad[1],
                          pipe_q[Depth-1].grad[0], pipe_q[Depth-1].w};
  assign m_axis_tuser  = pipe_q[Depth-1].coinc;

`ifndef SYNTHESIS
  logic s_fire, m_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;

  a_coinc_zero_grad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[127:32] == '0))
    else $error("coincident result with nonzero gradient");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == '0) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !m_fire) |=> ($countones(v_q) == $past($countones(v_q)) + 1))
    else $error("accepted transaction lost or duplicated");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_fire && m_fire) |=> ($countones(v_q) == $past($countones(v_q)) - 1))
    else $error("delivered transaction not retired");
`endif

endmodule

[sim/tb.sv]
// Testbench for the cubic spline kernel pipeline: predicts kernel value and gradient per pair.
module tb;
  import sphk_pkg::*;

  typedef struct packed {
    logic [31:0] kval;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic        coinc;
  } kres_t;

  class kernel_scoreboard;
    logic [31:0] inv_h;
    logic [31:0] val_scale;
    logic [31:0] grd_scale;
    kres_t       pending[$];
    int          errors;

    function new();
      inv_h = InvHReset;
      val_scale = ValScaleReset;
      grd_scale = GrdScaleReset;
      errors = 0;
    endfunction

    function logic [31:0] axis_grad(logic signed [63:0] d, logic [31:0] mag,
                                    logic [63:0] r);
      logic [63:0] ud;
      logic [95:0] m;
      logic signed [63:0] v;
      ud = (d < 0) ? -d : d;
      m = ({32'd0, mag} * {32'd0, ud}) / r;
      if (d > 0) begin
        if (m > 96'd2147483648) m = 96'd2147483648;
        v = -$signed(m[63:0]);
      end else begin
        if (m > 96'd2147483647) m = 96'd2147483647;
        v = m[63:0];
      end
      return v[31:0];
    endfunction

    function void note_pair(logic [191:0] data);
      logic signed [63:0] d[3];
      logic [127:0] d2, sq, c;
      logic [63:0] r, q, q2, q3, t, t2, t3;
      logic [127:0] prod, w, mag;
      logic signed [63:0] f, gm;
      logic in_supp;
      kres_t e;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = 64'($signed(data[32*i +: 32])) - 64'($signed(data[32*(i+3) +: 32]));
        sq = (d[i] < 0) ? -d[i] : d[i];
        d2 += sq * sq;
      end
      r = 0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c * c <= d2) r = c;
      end
      prod = {64'd0, r} * {96'd0, inv_h};
      in_supp = prod < (128'd1 << 49);
      f = 0;
      gm = 0;
      if (in_supp) begin
        q = prod >> 18;
        if (q < (64'd1 << 30)) begin
          q2 = (q * q) >> 30;
          q3 = (q2 * q) >> 30;
          f = 64'sd715827883 - $signed(q2) + $signed(q3 >> 1);
          gm = 2 * $signed(q) - $signed((3 * q2) >> 1);
        end else begin
          t = (64'd1 << 31) - q;
          t2 = (t * t) >> 30;
          t3 = (t2 * t) >> 30;
          f = t3 / 6;
          gm = t2 >> 1;
        end
        if (f < 0) f = 0;
        if (gm < 0) gm = 0;
      end
      w = ({96'd0, val_scale} * {64'd0, f}) >> 30;
      mag = ({96'd0, grd_scale} * {64'd0, gm}) >> 30;
      e.kval = (w > 128'hFFFFFFFF) ? 32'hFFFFFFFF : w[31:0];
      if (mag > 128'hFFFFFFFF) mag = 128'hFFFFFFFF;
      e.coinc = (d2 == 0);
      if (e.coinc || !in_supp || r == 0) begin
        e.gx = 0; e.gy = 0; e.gz = 0;
      end else begin
        e.gx = axis_grad(d[0], mag[31:0], r);
        e.gy = axis_grad(d[1], mag[31:0], r);
        e.gz = axis_grad(d[2], mag[31:0], r);
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_result(logic [127:0] data, logic user);
      kres_t e;
      kres_t a;
      a = {data[31:0], data[63:32], data[95:64], data[127:96], user};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.kval !== e.kval) begin
        $display("%0t: kernel_value expected %h actual %h", $time, e.kval, a.kval);
        errors++;
      end
      if (a.gx !== e.gx) begin
        $display("%0t: grad_x expected %h actual %h", $time, e.gx, a.gx);
        errors++;
      end
      if (a.gy !== e.gy) begin
        $display("%0t: grad_y expected %h actual %h", $time, e.gy, a.gy);
        errors++;
      end
      if (a.gz !== e.gz) begin
        $display("%0t: grad_z expected %h actual %h", $time, e.gz, a.gz);
        errors++;
      end
      if (a.coinc !== e.coinc) begin
        $display("%0t: coincident expected %b actual %b", $time, e.coinc, a.coinc);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         psel = 0;
  logic         penable = 0;
  logic         pwrite = 0;
  logic [3:0]   paddr = 0;
  logic [31:0]  pwdata = 0;
  logic [31:0]  prdata;
  logic         pready;

  kernel_scoreboard sb = new();
  int src_idle = 32;
  int snk_idle = 74;
  int hold_off = 0;

  sph_cubic_kernel_and_gradient dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= addr; pwdata <= value; penable <= 0;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 4 * RegInvH) sb.inv_h = value;
    else if (addr == 4 * RegValScale) sb.val_scale = value;
    else if (addr == 4 * RegGrdScale) sb.grd_scale = value;
  endtask

  task automatic send_pair(logic [191:0] data);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(data);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 0;
    while (sb.pending.size() > 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 32'h00800000)) - 32'sh00400000;
      2: v = $signed($urandom_range(0, 32'h00080000)) - 32'sh00040000;
      default: v = $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
    endcase
    return v;
  endfunction

  function automatic logic [191:0] rand_pair();
    logic [31:0] base[3];
    logic [191:0] p;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) base[i] = $urandom;
    for (int i = 0; i < 3; i++) begin
      p[32*i +: 32] = base[i];
      if (mode == 0) p[32*(i+3) +: 32] = $urandom;
      else if (mode == 1) p[32*(i+3) +: 32] = rand_coord(3);
      else if (mode == 2) p[32*(i+3) +: 32] = base[i];
      else if (mode < 6) p[32*(i+3) +: 32] = base[i] + rand_coord(1);
      else p[32*(i+3) +: 32] = base[i] + rand_coord(2);
    end
    return p;
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) send_pair(rand_pair());
  endtask

  initial begin
    logic [31:0] mx, mn, h;
    mx = 32'h7FFFFFFF;
    mn = 32'h80000000;
    h = 32'h00800000;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    send_pair({6{32'd0}});
    send_pair({mn, mn, mn, mx, mx, mx});
    send_pair({mx, mx, mx, mn, mn, mn});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, h});
    send_pair({32'd0, 32'd0, h, 32'd0, 32'd0, 32'd0});
    send_pair({32'd0, h, 32'd0, 32'd0, 32'd0, 32'd0});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h01000000});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h00333333});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h00199999});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h00000001});
    send_pair({32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
    send_pair({32'hFFFFFFFF, 32'd5, 32'hAAAAAAAA, 32'hFFFFFFFF, 32'd5, 32'hAAAAAAAA});
    drain();
    write_reg(4'(4 * RegInvH), 32'd0);
    write_reg(4'(4 * RegValScale), 32'hFFFFFFFF);
    write_reg(4'(4 * RegGrdScale), 32'hFFFFFFFF);
    send_pair({mn, mn, mn, mx, mx, mx});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
    drain();
    write_reg(4'(4 * RegInvH), 32'hFFFFFFFF);
    write_reg(4'(4 * RegValScale), 32'd0);
    write_reg(4'(4 * RegGrdScale), 32'd0);
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
    send_pair({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd100});
    drain();
    write_reg(4'(4 * RegInvH), 32'd1);
    write_reg(4'(4 * RegValScale), $urandom);
    write_reg(4'(4 * RegGrdScale), 32'hFFFFFFFF);
    random_phase(100);
    drain();
    write_reg(4'(4 * RegInvH), InvHReset);
    write_reg(4'(4 * RegValScale), ValScaleReset);
    write_reg(4'(4 * RegGrdScale), GrdScaleReset);
    random_phase(200);
    drain();
    src_idle = 74;
    snk_idle = 32;
    write_reg(4'(4 * RegInvH), 32'h10000000);
    write_reg(4'(4 * RegValScale), $urandom);
    write_reg(4'(4 * RegGrdScale), $urandom);
    random_phase(200);
    drain();
    src_idle = 0;
    snk_idle = 0;
    write_reg(4'(4 * RegInvH), $urandom);
    write_reg(4'(4 * RegValScale), 32'hFFFFFFFF);
    write_reg(4'(4 * RegGrdScale), 32'h7FFFFFFF);
    hold_off = 300;
    random_phase(150);
    drain();
    write_reg(4'(4 * RegInvH), InvHReset);
    write_reg(4'(4 * RegValScale), ValScaleReset);
    write_reg(4'(4 * RegGrdScale), GrdScaleReset);
    random_phase(150);
    drain();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/sphk_pkg.sv
rtl/sph_cubic_kernel_and_gradient.sv
sim/tb.sv
